[src/rbsi_pkg.sv]
// package: fixed point types, constants and helpers for the ray box slab block
`timescale 1ns / 1ps
`default_nettype none
package rbsi_pkg;
  localparam int FRAC_BITS_DEFAULT = 16;
  localparam int W = 32;
  localparam int QW = 8;
  localparam int RW = 2 * W + 2;
  localparam int NDIV = 2;

  typedef logic signed [W-1:0] q_t;

  typedef struct packed {
    q_t org_x;
    q_t org_y;
    q_t org_z;
    q_t dir_x;
    q_t dir_y;
    q_t dir_z;
  } ray_t;

  function automatic q_t clamp_w(input logic signed [RW-1:0] v);
    logic signed [RW-1:0] mx;
    logic signed [RW-1:0] mn;
    mx = RW'(signed'({1'b0, {(W-1){1'b1}}}));
    mn = -mx - RW'(1);
    if (v > mx) clamp_w = q_t'(mx);
    else if (v < mn) clamp_w = q_t'(mn);
    else clamp_w = q_t'(v);
  endfunction
endpackage
`default_nettype wire

[src/rbsi_if.sv]
// interfaces: ray input channel and hit result channel
`timescale 1ns / 1ps
`default_nettype none
interface rbsi_ray_if;
  logic valid;
  logic ready;
  logic signed [31:0] origin_x;
  logic signed [31:0] origin_y;
  logic signed [31:0] origin_z;
  logic signed [31:0] dir_x;
  logic signed [31:0] dir_y;
  logic signed [31:0] dir_z;
  modport source(output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                 input ready);
  modport sink(input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
               output ready);
endinterface

interface rbsi_hit_if;
  logic valid;
  logic ready;
  logic hit;
  logic signed [31:0] impact_x;
  logic signed [31:0] impact_y;
  logic signed [31:0] impact_z;
  modport source(output valid, hit, impact_x, impact_y, impact_z, input ready);
  modport sink(input valid, hit, impact_x, impact_y, impact_z, output ready);
endinterface
`default_nettype wire

[src/rbsi_fifo.sv]
// fifo: short queue between front and back
`timescale 1ns / 1ps
`default_nettype none
module rbsi_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [WIDTH-1:0] in_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic      [WIDTH-1:0] out_data
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0] wp;
  logic [AW-1:0] rp;
  logic [AW:0] cnt;
  logic push;
  logic pop;

  assign in_ready = cnt != (AW+1)'(DEPTH);
  assign out_valid = cnt != '0;
  assign out_data = mem[rp];
  assign push = in_valid && in_ready;
  assign pop = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= in_data;
    end
    if (rst) begin
      wp <= '0;
      rp <= '0;
      cnt <= '0;
    end else begin
      if (push) wp <= (wp == AW'(DEPTH-1)) ? '0 : wp + AW'(1);
      if (pop) rp <= (rp == AW'(DEPTH-1)) ? '0 : rp + AW'(1);
      cnt <= cnt + (AW+1)'(push) - (AW+1)'(pop);
    end
  end
endmodule
`default_nettype wire

[src/rbsi_front.sv]
// front: reciprocal of each direction component, pipelined restoring divider
`timescale 1ns / 1ps
`default_nettype none
module rbsi_front #(
  parameter int FRAC_BITS = rbsi_pkg::FRAC_BITS_DEFAULT
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire rbsi_pkg::ray_t   in_ray,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output rbsi_pkg::ray_t        out_ray,
  output rbsi_pkg::q_t          out_inv [3]
);
  import rbsi_pkg::*;
  // quotient bits: numerator 2^(2F) has 2F+1 bits
  localparam int QB = 2 * FRAC_BITS + 1;
  localparam int NS = (QB + NDIV - 1) / NDIV;

  typedef struct packed {
    logic [QB-1:0] rem;
    logic [QB-1:0] quo;
  } dv_t;

  logic          vld [NS+1];
  ray_t          ry  [NS+1];
  dv_t           dv  [NS+1][3];
  logic          adv;

  assign adv = !vld[NS] || out_ready;
  assign in_ready = adv;

  always_comb begin
    vld[0] = in_valid;
    ry[0] = in_ray;
    for (int a = 0; a < 3; a++) begin
      dv[0][a].rem = '0;
      dv[0][a].quo = '0;
    end
  end

  for (genvar s = 0; s < NS; s++) begin : g_stage
    dv_t nx [3];
    logic [W-1:0] dm [3];
    always_comb begin
      dm[0] = ry[s].dir_x[W-1] ? W'(-ry[s].dir_x) : W'(ry[s].dir_x);
      dm[1] = ry[s].dir_y[W-1] ? W'(-ry[s].dir_y) : W'(ry[s].dir_y);
      dm[2] = ry[s].dir_z[W-1] ? W'(-ry[s].dir_z) : W'(ry[s].dir_z);
    end
    always_comb begin
      logic [QB+W-1:0] r;
      int bi;
      for (int a = 0; a < 3; a++) begin
        r = (QB+W)'(dv[s][a].rem);
        nx[a].quo = dv[s][a].quo;
        for (int k = 0; k < NDIV; k++) begin
          bi = QB - 1 - (s * NDIV + k);
          if (bi >= 0) begin
            r = {r[QB+W-2:0], (bi == 2 * FRAC_BITS) ? 1'b1 : 1'b0};
            if (r >= (QB+W)'(dm[a])) begin
              r = r - (QB+W)'(dm[a]);
              nx[a].quo[bi] = 1'b1;
            end
          end
        end
        nx[a].rem = QB'(r);
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        ry[s+1] <= ry[s];
        dv[s+1] <= nx;
      end
      if (rst) vld[s+1] <= 1'b0;
      else if (adv) vld[s+1] <= vld[s];
    end
  end

  always_comb begin
    logic signed [RW-1:0] qs;
    logic [W-1:0] d;
    for (int a = 0; a < 3; a++) begin
      d = (a == 0) ? ry[NS].dir_x : (a == 1) ? ry[NS].dir_y : ry[NS].dir_z;
      qs = signed'(RW'(dv[NS][a].quo));
      if (d[W-1]) qs = -qs;
      out_inv[a] = (d == '0) ? q_t'({1'b0, {(W-1){1'b1}}}) : clamp_w(qs);
    end
  end
  assign out_valid = vld[NS];
  assign out_ray = ry[NS];
endmodule
`default_nettype wire

[src/rbsi_back.sv]
// back: slab products, interval narrowing and impact point
`timescale 1ns / 1ps
`default_nettype none
module rbsi_back #(
  parameter int FRAC_BITS = rbsi_pkg::FRAC_BITS_DEFAULT
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire rbsi_pkg::ray_t   in_ray,
  input  wire rbsi_pkg::q_t     in_inv [3],
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic                  out_hit,
  output rbsi_pkg::q_t          out_imp [3]
);
  import rbsi_pkg::*;
  localparam int PW = 2 * W + 2;

  function automatic q_t qmul_fin(input logic signed [PW-1:0] p);
    logic signed [PW-1:0] sh;
    sh = p >>> FRAC_BITS;
    qmul_fin = clamp_w(RW'(sh));
  endfunction

  logic v1, v2, v3, v4;
  logic adv;
  assign adv = !v4 || out_ready;
  assign in_ready = adv;

  // stage 1: slab products
  q_t org [3];
  q_t dir [3];
  assign org[0] = in_ray.org_x;
  assign org[1] = in_ray.org_y;
  assign org[2] = in_ray.org_z;
  assign dir[0] = in_ray.dir_x;
  assign dir[1] = in_ray.dir_y;
  assign dir[2] = in_ray.dir_z;

  logic signed [PW-1:0] plo [3];
  logic signed [PW-1:0] phi [3];
  q_t org1 [3];
  q_t dir1 [3];
  always_ff @(posedge clk) begin
    logic signed [W+1:0] one;
    logic signed [W+1:0] nb;
    logic signed [W+1:0] fb;
    one = (W+2)'(1) <<< FRAC_BITS;
    if (adv) begin
      for (int a = 0; a < 3; a++) begin
        nb = in_inv[a][W-1] ? one : -one;
        fb = -nb;
        plo[a] <= PW'(nb - (W+2)'(org[a])) * PW'(in_inv[a]);
        phi[a] <= PW'(fb - (W+2)'(org[a])) * PW'(in_inv[a]);
        org1[a] <= org[a];
        dir1[a] <= dir[a];
      end
    end
  end

  // stage 2: interval and distance choice
  q_t t2;
  logic h2;
  q_t org2 [3];
  q_t dir2 [3];
  always_ff @(posedge clk) begin
    q_t lo, hi, tmn, tmx;
    logic h;
    tmn = '0;
    tmx = '0;
    h = 1'b1;
    for (int a = 0; a < 3; a++) begin
      lo = qmul_fin(plo[a]);
      hi = qmul_fin(phi[a]);
      if (a == 0) begin
        tmn = lo;
        tmx = hi;
      end else if (h) begin
        if (tmn > hi || lo > tmx) h = 1'b0;
        else begin
          if (lo > tmn) tmn = lo;
          if (hi < tmx) tmx = hi;
        end
      end
    end
    if (adv) begin
      if (tmn[W-1]) begin
        t2 <= tmx;
        h2 <= h && !tmx[W-1];
      end else begin
        t2 <= tmn;
        h2 <= h;
      end
      org2 <= org1;
      dir2 <= dir1;
    end
  end

  // stage 3: t times direction
  logic signed [PW-1:0] pt [3];
  logic h3;
  q_t org3 [3];
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int a = 0; a < 3; a++) pt[a] <= PW'(t2) * PW'(dir2[a]);
      h3 <= h2;
      org3 <= org2;
    end
  end

  // stage 4: impact point
  always_ff @(posedge clk) begin
    if (adv) begin
      out_hit <= h3;
      for (int a = 0; a < 3; a++) begin
        out_imp[a] <= h3 ? clamp_w(RW'(org3[a]) + RW'(qmul_fin(pt[a]))) : '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end
  assign out_valid = v4;
endmodule
`default_nettype wire

[src/ray_box_slab_intersect.sv]
// top level: ray against the box [-1, 1] on each axis, slab method, Q fixed point
//
// usage: rays enter on the ray channel, one per cycle when the result side
// keeps up; one result per ray leaves on the hit channel, in order.
// path: the reciprocal first (two quotient bits per stage of a pipelined
// restoring divider, three lanes), then the queue, then the back end's
// registered stages for products, interval test and impact point.
// throughput: one ray per cycle when the receiver keeps up, set by the
// fully pipelined divider and the pipelined back end.
// the front and the back stall independently; an eight-entry queue sits
// between them. the back end holds all its stages when the receiver
// stalls, while the front takes new rays as long as the queue has room.
// reset (rst, synchronous) clears all valid flags and the queue; payload
// registers are not reset. a miss gives hit 0 and a zero impact point.
//
`timescale 1ns / 1ps
`default_nettype none
module ray_box_slab_intersect #(
  parameter int FRAC_BITS = rbsi_pkg::FRAC_BITS_DEFAULT
) (
  input wire logic clk,
  input wire logic rst,
  rbsi_ray_if.sink ray,
  rbsi_hit_if.source res
);
  import rbsi_pkg::*;
  localparam int QWID = 9 * W;

  ray_t in_ray;
  assign in_ray = '{org_x: ray.origin_x, org_y: ray.origin_y, org_z: ray.origin_z,
                    dir_x: ray.dir_x, dir_y: ray.dir_y, dir_z: ray.dir_z};

  logic f_valid, f_ready;
  ray_t f_ray;
  q_t f_inv [3];
  logic b_valid, b_ready;
  logic [QWID-1:0] b_data;
  ray_t b_ray;
  q_t b_inv [3];
  q_t imp [3];

  rbsi_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk, .rst, .in_valid(ray.valid), .in_ready(ray.ready), .in_ray,
    .out_valid(f_valid), .out_ready(f_ready), .out_ray(f_ray), .out_inv(f_inv)
  );

  rbsi_fifo #(.WIDTH(QWID), .DEPTH(QW)) u_queue (
    .clk, .rst, .in_valid(f_valid), .in_ready(f_ready),
    .in_data({f_ray, f_inv[0], f_inv[1], f_inv[2]}),
    .out_valid(b_valid), .out_ready(b_ready), .out_data(b_data)
  );

  assign b_ray = b_data[QWID-1 -: 6*W];
  assign b_inv[0] = b_data[3*W-1 -: W];
  assign b_inv[1] = b_data[2*W-1 -: W];
  assign b_inv[2] = b_data[W-1 -: W];

  rbsi_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk, .rst, .in_valid(b_valid), .in_ready(b_ready), .in_ray(b_ray),
    .in_inv(b_inv), .out_valid(res.valid), .out_ready(res.ready),
    .out_hit(res.hit), .out_imp(imp)
  );

  assign res.impact_x = imp[0];
  assign res.impact_y = imp[1];
  assign res.impact_z = imp[2];
endmodule
`default_nettype wire
